[rtl/dq_current_pi_vector_limit_top_macros.svh]
// Assertion macros for the dq current controller checker.
// Needs clk and rst_n in scope where they are used.
`ifndef DQ_CURRENT_PI_VECTOR_LIMIT_TOP_MACROS_SVH
`define DQ_CURRENT_PI_VECTOR_LIMIT_TOP_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define DQPI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqpi check failed");

// antecedent holds, consequent holds in the next cycle
`define DQPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqpi check failed");

`endif

[rtl/dqpi_pkg.sv]
// Shared constants, register indexes and saturation helpers for the dq controller.
// No dependencies.
package dqpi_pkg;

  localparam int SIG_WIDTH   = 16;
  localparam int FRAC_BITS   = 12;
  localparam int INTEG_WIDTH = 32;
  localparam int IEXTRA      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = 24;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_D          = 3'd0,
    REG_KI_D          = 3'd1,
    REG_KP_Q          = 3'd2,
    REG_KI_Q          = 3'd3,
    REG_VOLT_LIMIT    = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5,
    REG_DESAT_RATE    = 3'd6
  } reg_idx_t;

  localparam logic [0:0] OP_SAMPLE = 1'b0;
  localparam logic [0:0] OP_CLEAR  = 1'b1;

  // saturate a 50-bit sum to the integrator width
  function automatic logic signed [INTEG_WIDTH-1:0] sat_integ(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) sat_integ = 32'sh7FFFFFFF;
    else if (v < lo) sat_integ = 32'sh80000000;
    else sat_integ = v[INTEG_WIDTH-1:0];
  endfunction

  // saturate a 26-bit value to the signal width
  function automatic logic signed [SIG_WIDTH-1:0] sat_sig(input logic signed [25:0] v);
    if (v > 26'sd32767) sat_sig = 16'sh7FFF;
    else if (v < -26'sd32768) sat_sig = 16'sh8000;
    else sat_sig = v[SIG_WIDTH-1:0];
  endfunction

endpackage

[rtl/dqpi_mul.sv]
// Shared unsigned multiplier with registered product, used by every multiply step.
// Depends on dqpi_pkg.
module dqpi_mul
  import dqpi_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] mul_a,
  input  logic [MUL_B_W-1:0] mul_b,
  output logic [MUL_P_W-1:0] prod_r
);

  logic [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[rtl/dq_current_pi_vector_limit_top.sv]
// Top level of the dq axis PI current controller with voltage vector limit.
// Depends on dqpi_pkg and dqpi_mul.
//
//  channel | direction | beat contents
//  in_     | input     | operation, d_ref, d_meas, q_ref, q_meas
//  out_    | output    | volt_d, volt_q, clipped
//  cfg_    | input     | index, data (always ready)
//
// A clear beat goes straight to the result. A sample integrates, or decays after
// a clipped result (one shared 32x24 multiplier, one product per cycle); a limited
// vector adds a 16-step square root and two divides (none for a zero vector with
// zero limit). Reset clears the state and loads volt_limit with its
// maximum. A result the receiver has not taken holds the block in its last state,
// and a new beat waits until the block is back in idle.
module dq_current_pi_vector_limit_top
  import dqpi_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic signed [SIG_WIDTH-1:0] in_d_ref,
  input  logic signed [SIG_WIDTH-1:0] in_d_meas,
  input  logic signed [SIG_WIDTH-1:0] in_q_ref,
  input  logic signed [SIG_WIDTH-1:0] in_q_meas,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SIG_WIDTH-1:0] out_volt_d,
  output logic signed [SIG_WIDTH-1:0] out_volt_q,
  output logic                        out_clipped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_I1, S_I2, S_I3, S_I4, S_D1, S_D2, S_D3, S_P1, S_P2,
    S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQRT, S_R1, S_R2, S_DIV, S_R3, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] kp_r [2];
  logic [23:0] ki_r [2];
  logic [14:0] vlim_r;
  logic [23:0] ts_r;
  logic [23:0] desat_r;

  // controller state and working registers
  logic signed [INTEG_WIDTH-1:0] integ_r [2];
  logic                          clip_flag_r;
  logic signed [16:0]            e_r [2];
  logic signed [SIG_WIDTH-1:0]   u_r [2];
  logic                          ax_r;
  logic                          clip_r;
  logic [7:0]                    th_r;
  logic [MUL_P_W-1:0]            lo_r;
  logic [31:0]                   ss_r;
  logic [31:0]                   x_r;
  logic [17:0]                   rem_r;
  logic [15:0]                   root_r;
  logic [15:0]                   drem_r;
  logic [15:0]                   dd_r;
  logic [15:0]                   quo_r;
  logic [3:0]                    cnt_r;
  logic                          out_valid_r;
  logic signed [SIG_WIDTH-1:0]   out_d_r;
  logic signed [SIG_WIDTH-1:0]   out_q_r;
  logic                          out_clip_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod_r;

  dqpi_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // magnitudes of the current axis operands
  logic signed [16:0] e_neg;
  logic [15:0]        e_mag;
  logic               e_sgn;
  logic signed [16:0] u_neg;
  logic [15:0]        u_mag;
  logic               u_sgn;
  logic signed [INTEG_WIDTH:0] i_neg;
  logic [31:0]        i_mag;
  logic               i_sgn;

  assign e_sgn = e_r[ax_r][16];
  assign e_neg = -e_r[ax_r];
  assign e_mag = e_sgn ? e_neg[15:0] : e_r[ax_r][15:0];
  assign u_sgn = u_r[ax_r][SIG_WIDTH-1];
  assign u_neg = -(17'(u_r[ax_r]));
  assign u_mag = u_sgn ? u_neg[15:0] : u_r[ax_r];
  assign i_sgn = integ_r[ax_r][INTEG_WIDTH-1];
  assign i_neg = -(33'(integ_r[ax_r]));
  assign i_mag = i_sgn ? i_neg[31:0] : integ_r[ax_r];

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_I1:  begin mul_a = 32'(e_mag);       mul_b = ki_r[ax_r];          end
      S_I2:  begin mul_a = prod_r[31:0];     mul_b = ts_r;                end
      S_I3:  begin mul_a = 32'(th_r);        mul_b = ts_r;                end
      S_D1:  begin mul_a = i_mag;            mul_b = ts_r;                end
      S_D2:  begin mul_a = prod_r[55:24];    mul_b = desat_r;             end
      S_P1:  begin mul_a = 32'(e_mag);       mul_b = {kp_r[ax_r], 8'd0};  end
      S_SQ1: begin mul_a = 32'(u_mag);       mul_b = 24'(u_mag);          end
      S_SQ2: begin mul_a = 32'(u_mag);       mul_b = 24'(u_mag);          end
      S_SQ3: begin mul_a = 32'(vlim_r);      mul_b = 24'(vlim_r);         end
      S_R1:  begin mul_a = 32'(u_mag);       mul_b = 24'(vlim_r);         end
      default: begin mul_a = '0;             mul_b = '0;                  end
    endcase
  end

  // integrator gain step: (hi << 32 + lo) >> 16, signed by the error
  logic [63:0]        ig_full;
  logic [47:0]        ig_term;
  logic signed [49:0] ig_sum;
  assign ig_full = {prod_r[31:0], 32'd0} + {8'd0, lo_r};
  assign ig_term = ig_full[63:16];
  assign ig_sum  = e_sgn ? 50'(integ_r[ax_r]) - $signed({2'b0, ig_term})
                         : 50'(integ_r[ax_r]) + $signed({2'b0, ig_term});

  // decay step: integrator minus its scaled self
  logic [47:0]        dc_term;
  logic signed [49:0] dc_sum;
  assign dc_term = prod_r[55:8];
  assign dc_sum  = i_sgn ? 50'(integ_r[ax_r]) + $signed({2'b0, dc_term})
                         : 50'(integ_r[ax_r]) - $signed({2'b0, dc_term});

  // proportional sum, truncated toward zero by the extra fraction bits
  logic signed [41:0] pv_sum;
  logic signed [41:0] pv_adj;
  logic signed [25:0] pv_shr;
  assign pv_sum = e_sgn ? 42'(integ_r[ax_r]) - $signed({2'b0, prod_r[39:0]})
                        : 42'(integ_r[ax_r]) + $signed({2'b0, prod_r[39:0]});
  assign pv_adj = pv_sum[41] ? pv_sum + 42'sd65535 : pv_sum;
  assign pv_shr = pv_adj[41:IEXTRA];

  // square root digit step
  logic [19:0] sq_rt;
  logic [19:0] sq_trial;
  logic        sq_ge;
  logic [19:0] sq_diff;
  assign sq_rt    = {rem_r, x_r[31:30]};
  assign sq_trial = {2'b0, root_r, 2'b01};
  assign sq_ge    = sq_rt >= sq_trial;
  assign sq_diff  = sq_rt - sq_trial;

  // divide bit step, divisor is the root
  logic [16:0] dv_rt;
  logic        dv_ge;
  logic [16:0] dv_diff;
  assign dv_rt   = {drem_r, dd_r[15]};
  assign dv_ge   = dv_rt >= {1'b0, root_r};
  assign dv_diff = dv_rt - {1'b0, root_r};

  // signed, saturated quotient
  logic signed [25:0] rs_val;
  assign rs_val = u_sgn ? -$signed(26'(quo_r)) : $signed(26'(quo_r));

  logic in_acc;
  logic out_free;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kp_r[0]     <= '0;
      kp_r[1]     <= '0;
      ki_r[0]     <= '0;
      ki_r[1]     <= '0;
      vlim_r      <= 15'h7FFF;
      ts_r        <= '0;
      desat_r     <= '0;
      integ_r[0]  <= '0;
      integ_r[1]  <= '0;
      clip_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
      ax_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // the last state reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          REG_KP_D:          kp_r[0] <= cfg_data[15:0];
          REG_KI_D:          ki_r[0] <= cfg_data;
          REG_KP_Q:          kp_r[1] <= cfg_data[15:0];
          REG_KI_Q:          ki_r[1] <= cfg_data;
          REG_VOLT_LIMIT:    vlim_r  <= cfg_data[14:0];
          REG_SAMPLE_PERIOD: ts_r    <= cfg_data;
          REG_DESAT_RATE:    desat_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ax_r <= 1'b0;
            if (in_operation == OP_CLEAR) begin
              integ_r[0]  <= '0;
              integ_r[1]  <= '0;
              clip_flag_r <= 1'b0;
              u_r[0]      <= '0;
              u_r[1]      <= '0;
              clip_r      <= 1'b0;
              state_r     <= S_DONE;
            end else begin
              e_r[0]  <= 17'(in_d_ref) - 17'(in_d_meas);
              e_r[1]  <= 17'(in_q_ref) - 17'(in_q_meas);
              state_r <= clip_flag_r ? S_D1 : S_I1;
            end
          end
        end
        S_I1: state_r <= S_I2;
        S_I2: begin
          th_r    <= prod_r[39:32];
          state_r <= S_I3;
        end
        S_I3: begin
          lo_r    <= prod_r;
          state_r <= S_I4;
        end
        S_I4: begin
          integ_r[ax_r] <= sat_integ(ig_sum);
          state_r       <= S_P1;
        end
        S_D1: state_r <= S_D2;
        S_D2: state_r <= S_D3;
        S_D3: begin
          integ_r[ax_r] <= sat_integ(dc_sum);
          state_r       <= S_P1;
        end
        S_P1: state_r <= S_P2;
        S_P2: begin
          u_r[ax_r] <= sat_sig(pv_shr);
          if (!ax_r) begin
            ax_r    <= 1'b1;
            state_r <= clip_flag_r ? S_D1 : S_I1;
          end else begin
            ax_r    <= 1'b0;
            state_r <= S_SQ1;
          end
        end
        S_SQ1: begin
          ax_r    <= 1'b1;
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          ss_r    <= prod_r[31:0];
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          ss_r    <= ss_r + prod_r[31:0];
          state_r <= S_SQ4;
        end
        S_SQ4: begin
          clip_r <= ss_r >= prod_r[31:0];
          x_r    <= ss_r;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
          ax_r   <= 1'b0;
          state_r <= (ss_r >= prod_r[31:0]) ? S_SQRT : S_DONE;
        end
        S_SQRT: begin
          x_r   <= {x_r[29:0], 2'b00};
          cnt_r <= cnt_r + 4'd1;
          if (sq_ge) begin
            rem_r  <= sq_diff[17:0];
            root_r <= {root_r[14:0], 1'b1};
          end else begin
            rem_r  <= sq_rt[17:0];
            root_r <= {root_r[14:0], 1'b0};
          end
          if (cnt_r == 4'hF) begin
            // zero vector with zero limit: both axes go to zero
            if (root_r[14:0] == '0 && !sq_ge) begin
              u_r[0]  <= '0;
              u_r[1]  <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_R1;
            end
          end
        end
        S_R1: state_r <= S_R2;
        S_R2: begin
          drem_r  <= {2'b0, prod_r[29:16]};
          dd_r    <= prod_r[15:0];
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dd_r  <= {dd_r[14:0], 1'b0};
          cnt_r <= cnt_r + 4'd1;
          if (dv_ge) begin
            drem_r <= dv_diff[15:0];
            quo_r  <= {quo_r[14:0], 1'b1};
          end else begin
            drem_r <= dv_rt[15:0];
            quo_r  <= {quo_r[14:0], 1'b0};
          end
          if (cnt_r == 4'hF) state_r <= S_R3;
        end
        S_R3: begin
          u_r[ax_r] <= sat_sig(rs_val);
          if (!ax_r) begin
            ax_r    <= 1'b1;
            state_r <= S_R1;
          end else begin
            ax_r    <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_d_r     <= u_r[0];
            out_q_r     <= u_r[1];
            out_clip_r  <= clip_r;
            clip_flag_r <= clip_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_volt_d  = out_d_r;
  assign out_volt_q  = out_q_r;
  assign out_clipped = out_clip_r;

endmodule

[rtl/dqpi_checker.sv]
// Port-level checks for the dq current controller, bound to its top level.
// Depends on dqpi_pkg and the assertion macro header.
`include "dq_current_pi_vector_limit_top_macros.svh"

module dqpi_checker
  import dqpi_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [SIG_WIDTH-1:0] out_volt_d,
  input logic signed [SIG_WIDTH-1:0] out_volt_q,
  input logic                        out_clipped
);

  // busy after every accepted beat
  `DQPI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // ready drops only because a beat was taken
  `DQPI_ASSERT_IMPL(a_ready_falls_on_accept, $fell(in_ready), $past(in_valid))

  // a stalled result stays offered
  `DQPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `DQPI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_volt_d) && $stable(out_volt_q) && $stable(out_clipped))

endmodule

bind dq_current_pi_vector_limit_top dqpi_checker u_dqpi_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for dq_current_pi_vector_limit_top: directed and random beats
// over several register settings and idle patterns. Depends on dqpi_pkg and the RTL.
module testbench;
  import dqpi_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    shortint volt_d;
    shortint volt_q;
    bit      clipped;
  } volt_cmd_t;

  // predicts the voltage command of each sample and checks the block's results
  class dq_scoreboard;
    longint unsigned kp_d, ki_d, kp_q, ki_q, volt_limit, sample_period, desat_rate;
    longint integ_d, integ_q;
    bit clip_flag;
    volt_cmd_t cmd_q[$];
    int errors;

    function new();
      kp_d = 0; ki_d = 0; kp_q = 0; ki_q = 0;
      volt_limit = 32767; sample_period = 0; desat_rate = 0;
      integ_d = 0; integ_q = 0; clip_flag = 0; errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, longint unsigned val);
      case (idx)
        REG_KP_D:          kp_d = val & 16'hFFFF;
        REG_KI_D:          ki_d = val & 24'hFFFFFF;
        REG_KP_Q:          kp_q = val & 16'hFFFF;
        REG_KI_Q:          ki_q = val & 24'hFFFFFF;
        REG_VOLT_LIMIT:    volt_limit = val & 15'h7FFF;
        REG_SAMPLE_PERIOD: sample_period = val & 24'hFFFFFF;
        REG_DESAT_RATE:    desat_rate = val & 24'hFFFFFF;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // (a * b) >> s toward zero, magnitude capped at 2^62
    function longint prod_shift(longint a, longint unsigned b, int s);
      bit [127:0] p;
      longint unsigned m;
      bit neg;
      neg = a < 0;
      m = neg ? -a : a;
      p = {64'b0, m} * {64'b0, b};
      p = p >> s;
      if (p > (128'd1 << 62)) p = 128'd1 << 62;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned r, trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (longint'(1) << b);
        if (trial * trial <= x) r = trial;
      end
      return r;
    endfunction

    function longint shrink(longint v, longint unsigned mag);
      longint unsigned m, q;
      m = (v < 0) ? -v : v;
      q = (m * volt_limit) / mag;
      return clamp((v < 0) ? -longint'(q) : longint'(q), SIG_WIDTH);
    endfunction

    function void note_sample(bit op, shortint d_ref, shortint d_meas,
                              shortint q_ref, shortint q_meas);
      volt_cmd_t c;
      longint ed, eq, ud, uq;
      longint unsigned sumsq, mag;
      bit clip;
      if (op == OP_CLEAR) begin
        integ_d = 0; integ_q = 0; clip_flag = 0;
        c.volt_d = 0; c.volt_q = 0; c.clipped = 0;
        cmd_q.push_back(c);
        return;
      end
      ed = longint'(d_ref) - longint'(d_meas);
      eq = longint'(q_ref) - longint'(q_meas);
      // integrate while unclipped, otherwise bleed off
      if (!clip_flag) begin
        integ_d = clamp(integ_d + prod_shift(prod_shift(ed, ki_d, 0), sample_period, 16), 32);
        integ_q = clamp(integ_q + prod_shift(prod_shift(eq, ki_q, 0), sample_period, 16), 32);
      end else begin
        integ_d = clamp(integ_d - prod_shift(prod_shift(integ_d, sample_period, 24),
                                             desat_rate, 8), 32);
        integ_q = clamp(integ_q - prod_shift(prod_shift(integ_q, sample_period, 24),
                                             desat_rate, 8), 32);
      end
      ud = clamp((integ_d + ed * longint'(kp_d) * 256) / 65536, SIG_WIDTH);
      uq = clamp((integ_q + eq * longint'(kp_q) * 256) / 65536, SIG_WIDTH);
      // vector limit
      sumsq = ud * ud + uq * uq;
      clip = sumsq >= volt_limit * volt_limit;
      if (clip) begin
        mag = floor_root(sumsq);
        if (mag == 0) begin
          ud = 0; uq = 0;
        end else begin
          ud = shrink(ud, mag);
          uq = shrink(uq, mag);
        end
      end
      clip_flag = clip;
      c.volt_d = shortint'(ud); c.volt_q = shortint'(uq); c.clipped = clip;
      cmd_q.push_back(c);
    endfunction

    function void check_cmd(shortint vd, shortint vq, bit clipped);
      volt_cmd_t c;
      if (cmd_q.size() == 0) begin
        $error("unexpected result beat: volt_d %0d volt_q %0d", vd, vq);
        errors++;
        return;
      end
      c = cmd_q.pop_front();
      if (vd !== c.volt_d) begin
        $error("volt_d: expected %0d, got %0d", c.volt_d, vd); errors++;
      end
      if (vq !== c.volt_q) begin
        $error("volt_q: expected %0d, got %0d", c.volt_q, vq); errors++;
      end
      if (clipped !== c.clipped) begin
        $error("clipped: expected %0d, got %0d", c.clipped, clipped); errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_operation = OP_SAMPLE;
  logic signed [SIG_WIDTH-1:0] in_d_ref = '0;
  logic signed [SIG_WIDTH-1:0] in_d_meas = '0;
  logic signed [SIG_WIDTH-1:0] in_q_ref = '0;
  logic signed [SIG_WIDTH-1:0] in_q_meas = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SIG_WIDTH-1:0] out_volt_d;
  logic signed [SIG_WIDTH-1:0] out_volt_q;
  logic                        out_clipped;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_KP_D;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  dq_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  dq_current_pi_vector_limit_top u_top (.*);

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // monitor: feed the predictor, check results, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_sample(in_operation, in_d_ref, in_d_meas, in_q_ref, in_q_meas);
      if (out_valid && out_ready)
        sb.check_cmd(out_volt_d, out_volt_q, out_clipped);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, 64'(val));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(int unsigned kpd, kid, kpq, kiq, lim, sp, dr);
    write_reg(REG_KP_D, kpd);
    write_reg(REG_KI_D, kid);
    write_reg(REG_KP_Q, kpq);
    write_reg(REG_KI_Q, kiq);
    write_reg(REG_VOLT_LIMIT, lim);
    write_reg(REG_SAMPLE_PERIOD, sp);
    write_reg(REG_DESAT_RATE, dr);
  endtask

  // one input beat; valid stays up across back-to-back beats
  task automatic send_beat(bit op, shortint dr, shortint dm, shortint qr, shortint qm);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_d_ref     <= dr;
    in_d_meas    <= dm;
    in_q_ref     <= qr;
    in_q_meas    <= qm;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic shortint rand_sig(int span);
    if (span == 0 || $urandom_range(3) == 0) return shortint'($urandom);
    return shortint'($urandom_range(2 * span) - span);
  endfunction

  task automatic random_beats(int n, int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        send_beat(OP_CLEAR, rand_sig(0), rand_sig(0), rand_sig(0), rand_sig(0));
      else
        send_beat(OP_SAMPLE, rand_sig(span), rand_sig(span), rand_sig(span), rand_sig(span));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gains zero, full limit
    send_beat(OP_SAMPLE, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF);
    send_beat(OP_SAMPLE, 0, 0, 0, 0);
    random_beats(20, 4096);
    drain();

    // all registers at maximum: saturation, clipping, decay factor above one
    write_all(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(OP_SAMPLE, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
    send_beat(OP_SAMPLE, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
    send_beat(OP_SAMPLE, 16'sh7FFF, -16'sh8000, 0, 0);
    send_beat(OP_SAMPLE, 0, 0, -16'sh8000, 16'sh7FFF);
    send_beat(OP_SAMPLE, 1, 0, 0, 1);
    send_beat(OP_CLEAR, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_beat(OP_SAMPLE, 0, 0, 0, 0);
    send_beat(OP_SAMPLE, -1, -1, -1, -1);
    drain();

    // zero gains and zero limit: zero vector is clipped
    write_all(0, 0, 0, 0, 0, 0, 0);
    send_beat(OP_SAMPLE, 0, 0, 0, 0);
    send_beat(OP_SAMPLE, 16'sh7FFF, 0, -16'sh8000, 0);
    send_beat(OP_CLEAR, 0, 0, 0, 0);
    drain();

    // random settings, cycling the idle patterns
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      write_all($urandom_range(0, 16'h0800), $urandom_range(0, 24'hFFFFFF),
                $urandom_range(0, 16'h0800), $urandom_range(0, 24'hFFFFFF),
                (p == 7) ? 15'h7FFF : $urandom_range(0, 15'h7FFF),
                (p % 3 == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 4000),
                $urandom_range(0, 24'hFFFFFF));
      random_beats(70, (p % 2) ? 2048 : 0);
      drain();
    end

    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
